// ===== design/sbe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sbe_pkg;

    // Sizes of the machine.
    localparam int STACK_DEPTH   = 64;
    localparam int FRAME_VARS    = 16;
    localparam int CALL_DEPTH    = 16;
    localparam int PROGRAM_WORDS = 4096;
    localparam int DATA_WIDTH    = 32;
    localparam int IN_Q_DEPTH    = 2;

    // Fixed field widths of the item and result.
    localparam int FUNC_W   = 5;
    localparam int IMM_W    = 32;
    localparam int SLOT_W   = 4;
    localparam int ADDR_W   = 12;
    localparam int STATUS_W = 4;

    // Derived widths.
    localparam int PC_W   = $clog2(PROGRAM_WORDS);
    localparam int SP_W   = (STACK_DEPTH > 2) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int CD_W   = (CALL_DEPTH > 1) ? $clog2(CALL_DEPTH) : 1;
    localparam int FV_W   = (FRAME_VARS > 1) ? $clog2(FRAME_VARS) : 1;
    localparam int FA_W   = CD_W + FV_W;
    localparam int DCNT_W = $clog2(DATA_WIDTH + 1);
    localparam int QP_W   = (IN_Q_DEPTH > 1) ? $clog2(IN_Q_DEPTH) : 1;
    localparam int QC_W   = $clog2(IN_Q_DEPTH + 1);

    // Opcodes.
    localparam logic [FUNC_W-1:0] OP_LOAD    = 5'd0;
    localparam logic [FUNC_W-1:0] OP_CONST   = 5'd1;
    localparam logic [FUNC_W-1:0] OP_STORE   = 5'd2;
    localparam logic [FUNC_W-1:0] OP_GOTO    = 5'd3;
    localparam logic [FUNC_W-1:0] OP_ADD     = 5'd4;
    localparam logic [FUNC_W-1:0] OP_SUB     = 5'd5;
    localparam logic [FUNC_W-1:0] OP_MUL     = 5'd6;
    localparam logic [FUNC_W-1:0] OP_DIV     = 5'd7;
    localparam logic [FUNC_W-1:0] OP_NOT     = 5'd8;
    localparam logic [FUNC_W-1:0] OP_AND     = 5'd9;
    localparam logic [FUNC_W-1:0] OP_OR      = 5'd10;
    localparam logic [FUNC_W-1:0] OP_EQ      = 5'd11;
    localparam logic [FUNC_W-1:0] OP_LT      = 5'd12;
    localparam logic [FUNC_W-1:0] OP_GT      = 5'd13;
    localparam logic [FUNC_W-1:0] OP_CALL    = 5'd14;
    localparam logic [FUNC_W-1:0] OP_RETURN  = 5'd15;
    localparam logic [FUNC_W-1:0] OP_PRINT   = 5'd16;
    localparam logic [FUNC_W-1:0] OP_IFFALSE = 5'd17;
    localparam logic [FUNC_W-1:0] OP_STOP    = 5'd18;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 4'd0;
    localparam logic [STATUS_W-1:0] ST_STOPPED   = 4'd1;
    localparam logic [STATUS_W-1:0] ST_HALTED    = 4'd2;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 4'd3;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 4'd4;
    localparam logic [STATUS_W-1:0] ST_DIV_ZERO  = 4'd5;
    localparam logic [STATUS_W-1:0] ST_CALL_OVF  = 4'd6;
    localparam logic [STATUS_W-1:0] ST_RET_UNF   = 4'd7;
    localparam logic [STATUS_W-1:0] ST_VAR_UNSET = 4'd8;
    localparam logic [STATUS_W-1:0] ST_BAD_OP    = 4'd9;

    typedef struct packed {
        logic [FUNC_W-1:0]       func;
        logic signed [IMM_W-1:0] immediate;
        logic [SLOT_W-1:0]       var_slot;
        logic [ADDR_W-1:0]       target_address;
    } in_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0]       fetch_address;
        logic                    print_valid;
        logic signed [IMM_W-1:0] print_value;
        logic [STATUS_W-1:0]     status;
        logic                    halted_flag;
    } result_t;

    // Class worked out by the front end.
    typedef struct packed {
        logic       bad;
        logic [1:0] pops;
    } op_class_t;

    typedef struct packed {
        in_item_t  item;
        op_class_t cls;
    } q_entry_t;

endpackage

`default_nettype wire

// ===== design/stack_bytecode_executor.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A result is registered after its item leaves the input queue: the operand
// stack and frame memories are read, then the instruction executes; a divide
// then iterates in its own divide state before it finishes. A new instruction
// is taken only once the last is done and the output register is free or popped.
// Reset (rst_n low, asynchronous) empties both queues, the stack, call depth and
// halted flag, and sets the program counter to zero; memories are not cleared.

module stack_bytecode_executor (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [11:0]       cfg_wdata,
    input  wire logic              push,
    output logic                   full,
    input  wire sbe_pkg::in_item_t item,
    output logic                   empty,
    input  wire logic              pop,
    output sbe_pkg::result_t       result
);
    import sbe_pkg::*;

    // The front end takes each transfer into a short queue and classifies the
    // opcode by how many operands it needs, so the back end can check for
    // underflow without decoding again.
    logic     head_valid;
    logic     head_pop;
    q_entry_t head;

    sbe_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .item       (item),
        .head_valid (head_valid),
        .head       (head),
        .head_pop   (head_pop)
    );

    // The back end holds all architectural state. It reads the stack memory
    // and frame memory in one cycle and commits in the next, keeping the top
    // of stack in a register. Its output register lets a finished result wait
    // while further input transfers are still taken by the front end.
    sbe_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .head_valid (head_valid),
        .head       (head),
        .head_pop   (head_pop),
        .empty      (empty),
        .pop        (pop),
        .result     (result)
    );

endmodule

`default_nettype wire

// ===== design/sbe_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sbe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 2) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== design/sbe_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sbe_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire sbe_pkg::in_item_t item,
    output logic                   head_valid,
    output sbe_pkg::q_entry_t      head,
    input  wire logic              head_pop
);
    import sbe_pkg::*;

    q_entry_t          q_reg [IN_Q_DEPTH];
    logic [QP_W-1:0]   wr_reg, wr_next;
    logic [QP_W-1:0]   rd_reg, rd_next;
    logic [QC_W-1:0]   cnt_reg, cnt_next;
    op_class_t         cls;
    logic              do_push;
    logic              do_pop;

    // Sort the opcode by how many operands it consumes.
    always_comb
    begin
        cls.bad  = 1'b0;
        cls.pops = 2'd0;
        case (item.func)
            OP_LOAD, OP_CONST, OP_GOTO, OP_CALL, OP_RETURN, OP_STOP:
                cls.pops = 2'd0;
            OP_STORE, OP_NOT, OP_PRINT, OP_IFFALSE:
                cls.pops = 2'd1;
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_AND, OP_OR, OP_EQ, OP_LT, OP_GT:
                cls.pops = 2'd2;
            default:
                cls.bad = 1'b1;
        endcase
    end

    assign full       = (cnt_reg == QC_W'(IN_Q_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head       = q_reg[rd_reg];
    assign do_push    = push && !full;
    assign do_pop     = head_pop && head_valid;

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push)
        begin
            wr_next = (wr_reg == QP_W'(IN_Q_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_next = (rd_reg == QP_W'(IN_Q_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_reg] <= '{item: item, cls: cls};
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QC_W'(IN_Q_DEPTH))
        else $error("input queue count beyond depth");

    a_push_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("lone push did not raise the count");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0) |=> (rd_reg == $past(rd_reg)))
        else $error("read pointer moved while queue was empty");

endmodule

`default_nettype wire

// ===== design/sbe_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sbe_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [11:0]        cfg_wdata,
    input  wire logic               head_valid,
    input  wire sbe_pkg::q_entry_t  head,
    output logic                    head_pop,
    output logic                    empty,
    input  wire logic               pop,
    output sbe_pkg::result_t        result
);
    import sbe_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;

    logic [1:0]            st_reg, st_next;
    q_entry_t              cur_reg, cur_next;
    logic [PC_W-1:0]       pc_reg, pc_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DATA_WIDTH-1:0] tos_reg, tos_next;
    logic [CD_W-1:0]       depth_reg, depth_next;
    logic                  halted_reg, halted_next;
    logic [FRAME_VARS-1:0] fvalid_reg [CALL_DEPTH];
    logic [FRAME_VARS-1:0] fvalid_next [CALL_DEPTH];
    logic [PC_W-1:0]       ret_reg [CALL_DEPTH];
    logic [PC_W-1:0]       ret_next [CALL_DEPTH];
    logic [DATA_WIDTH-1:0] rem_reg, rem_next;
    logic [DATA_WIDTH-1:0] quo_reg, quo_next;
    logic [DATA_WIDTH-1:0] dmb_reg, dmb_next;
    logic                  dneg_reg, dneg_next;
    logic [DCNT_W-1:0]     dcnt_reg, dcnt_next;
    logic                  out_valid_reg, out_valid_next;
    result_t               out_reg, out_next;

    logic                  start;
    logic                  stk_we;
    logic [SP_W-1:0]       stk_waddr;
    logic [SP_W-1:0]       stk_raddr;
    logic [DATA_WIDTH-1:0] stk_rdata;
    logic                  fr_we;
    logic [FA_W-1:0]       fr_waddr;
    logic [FA_W-1:0]       fr_raddr;
    logic [DATA_WIDTH-1:0] fr_rdata;
    logic [CNT_W-1:0]      cnt_m2;

    assign start    = (st_reg == S_IDLE) && head_valid && (!out_valid_reg || pop);
    assign head_pop = start;
    assign empty    = !out_valid_reg;
    assign result   = out_reg;
    assign cnt_m2   = cnt_reg - CNT_W'(2);
    assign stk_raddr = cnt_m2[SP_W-1:0];
    assign fr_raddr  = {depth_reg, FV_W'(head.item.var_slot)};

    sbe_ram #(.WIDTH(DATA_WIDTH), .DEPTH(STACK_DEPTH)) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (tos_reg),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    sbe_ram #(.WIDTH(DATA_WIDTH), .DEPTH(2 ** FA_W)) u_frame_ram (
        .clk   (clk),
        .we    (fr_we),
        .waddr (fr_waddr),
        .wdata (tos_reg),
        .raddr (fr_raddr),
        .rdata (fr_rdata)
    );

    always_comb
    begin
        logic [PC_W-1:0]       pc1;
        logic [STATUS_W-1:0]   status;
        logic                  pvalid;
        logic [DATA_WIDTH-1:0] pval;
        logic                  emit;
        logic                  do_push;
        logic [DATA_WIDTH-1:0] push_val;
        logic [DATA_WIDTH-1:0] a;
        logic [DATA_WIDTH-1:0] b;
        logic [DATA_WIDTH-1:0] r;
        logic [DATA_WIDTH:0]   rs;
        logic [DATA_WIDTH-1:0] q;
        logic [FV_W-1:0]       slot;
        logic                  slot_ok;
        logic [CD_W-1:0]       dn;

        st_next        = st_reg;
        cur_next       = cur_reg;
        pc_next        = pc_reg;
        cnt_next       = cnt_reg;
        tos_next       = tos_reg;
        depth_next     = depth_reg;
        halted_next    = halted_reg;
        fvalid_next    = fvalid_reg;
        ret_next       = ret_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        dmb_next       = dmb_reg;
        dneg_next      = dneg_reg;
        dcnt_next      = dcnt_reg;
        out_valid_next = out_valid_reg && !pop;
        out_next       = out_reg;
        stk_we         = 1'b0;
        stk_waddr      = '0;
        fr_we          = 1'b0;
        fr_waddr       = '0;

        pc1      = pc_reg + 1'b1;
        status   = ST_OK;
        pvalid   = 1'b0;
        pval     = '0;
        emit     = 1'b0;
        do_push  = 1'b0;
        push_val = '0;
        a        = stk_rdata;
        b        = tos_reg;
        r        = '0;
        rs       = '0;
        q        = '0;
        slot     = FV_W'(cur_reg.item.var_slot);
        slot_ok  = ({{(32 - SLOT_W){1'b0}}, cur_reg.item.var_slot} < FRAME_VARS);
        dn       = depth_reg + 1'b1;

        case (st_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cur_next = head;
                    st_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                st_next = S_IDLE;
                emit    = 1'b1;
                if (halted_reg)
                begin
                    status = ST_HALTED;
                end
                else
                begin
                    pc_next = pc1;
                    if (cur_reg.cls.bad)
                    begin
                        status = ST_BAD_OP;
                    end
                    else if (CNT_W'(cur_reg.cls.pops) > cnt_reg)
                    begin
                        status = ST_UNDERFLOW;
                    end
                    else
                    begin
                        case (cur_reg.item.func)
                            OP_STOP:
                                status = ST_STOPPED;
                            OP_LOAD:
                            begin
                                if (!slot_ok || !fvalid_reg[depth_reg][slot])
                                begin
                                    status = ST_VAR_UNSET;
                                end
                                else if (cnt_reg >= CNT_W'(STACK_DEPTH))
                                begin
                                    status = ST_OVERFLOW;
                                end
                                else
                                begin
                                    do_push  = 1'b1;
                                    push_val = fr_rdata;
                                end
                            end
                            OP_CONST:
                            begin
                                if (cnt_reg >= CNT_W'(STACK_DEPTH))
                                begin
                                    status = ST_OVERFLOW;
                                end
                                else
                                begin
                                    do_push  = 1'b1;
                                    push_val = DATA_WIDTH'(cur_reg.item.immediate);
                                end
                            end
                            OP_GOTO:
                                pc_next = PC_W'(cur_reg.item.target_address);
                            OP_CALL:
                            begin
                                if ({{(32 - CD_W){1'b0}}, depth_reg} + 1 >= CALL_DEPTH)
                                begin
                                    status = ST_CALL_OVF;
                                end
                                else
                                begin
                                    ret_next[depth_reg] = pc1;
                                    depth_next          = dn;
                                    fvalid_next[dn]     = '0;
                                    pc_next = PC_W'(cur_reg.item.target_address) + 1'b1;
                                end
                            end
                            OP_RETURN:
                            begin
                                if (depth_reg == '0)
                                begin
                                    status = ST_RET_UNF;
                                end
                                else
                                begin
                                    depth_next = depth_reg - 1'b1;
                                    pc_next    = ret_reg[depth_reg - 1'b1];
                                end
                            end
                            OP_STORE, OP_PRINT, OP_IFFALSE:
                            begin
                                cnt_next = cnt_reg - 1'b1;
                                tos_next = stk_rdata;
                                if (cur_reg.item.func == OP_STORE)
                                begin
                                    if (slot_ok)
                                    begin
                                        fr_we    = 1'b1;
                                        fr_waddr = {depth_reg, slot};
                                        fvalid_next[depth_reg][slot] = 1'b1;
                                    end
                                end
                                else if (cur_reg.item.func == OP_PRINT)
                                begin
                                    pvalid = 1'b1;
                                    pval   = tos_reg;
                                end
                                else
                                begin
                                    pc_next = (tos_reg == '0)
                                        ? PC_W'(cur_reg.item.target_address)
                                        : pc1 + 1'b1;
                                end
                            end
                            OP_NOT:
                                tos_next = (tos_reg == '0) ? DATA_WIDTH'(1) : '0;
                            OP_DIV:
                            begin
                                if (b == '0)
                                begin
                                    status = ST_DIV_ZERO;
                                end
                                else
                                begin
                                    emit      = 1'b0;
                                    st_next   = S_DIV;
                                    rem_next  = '0;
                                    quo_next  = a[DATA_WIDTH-1] ? -a : a;
                                    dmb_next  = b[DATA_WIDTH-1] ? -b : b;
                                    dneg_next = a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
                                    dcnt_next = DCNT_W'(DATA_WIDTH);
                                end
                            end
                            default:
                            begin
                                case (cur_reg.item.func)
                                    OP_ADD: r = a + b;
                                    OP_SUB: r = a - b;
                                    OP_MUL: r = a * b;
                                    OP_AND: r = DATA_WIDTH'((a != '0) && (b != '0));
                                    OP_OR:  r = DATA_WIDTH'((a != '0) || (b != '0));
                                    OP_EQ:  r = DATA_WIDTH'(a == b);
                                    OP_LT:  r = DATA_WIDTH'($signed(a) < $signed(b));
                                    default: r = DATA_WIDTH'($signed(b) < $signed(a));
                                endcase
                                cnt_next = cnt_reg - 1'b1;
                                tos_next = r;
                            end
                        endcase
                    end
                    if (do_push)
                    begin
                        if (cnt_reg != '0)
                        begin
                            stk_we    = 1'b1;
                            stk_waddr = SP_W'(cnt_reg - 1'b1);
                        end
                        tos_next = push_val;
                        cnt_next = cnt_reg + 1'b1;
                    end
                    if (status != ST_OK)
                    begin
                        halted_next = 1'b1;
                    end
                end
            end
            S_DIV:
            begin
                if (dcnt_reg == '0)
                begin
                    q        = quo_reg;
                    tos_next = dneg_reg ? -q : q;
                    cnt_next = cnt_reg - 1'b1;
                    st_next  = S_IDLE;
                    emit     = 1'b1;
                end
                else
                begin
                    rs = {rem_reg, quo_reg[DATA_WIDTH-1]};
                    if (rs >= {1'b0, dmb_reg})
                    begin
                        rs       = rs - {1'b0, dmb_reg};
                        quo_next = {quo_reg[DATA_WIDTH-2:0], 1'b1};
                    end
                    else
                    begin
                        quo_next = {quo_reg[DATA_WIDTH-2:0], 1'b0};
                    end
                    rem_next  = rs[DATA_WIDTH-1:0];
                    dcnt_next = dcnt_reg - 1'b1;
                end
            end
            default:
                st_next = S_IDLE;
        endcase

        if (emit)
        begin
            out_valid_next        = 1'b1;
            out_next.fetch_address = ADDR_W'(PC_W'(pc_next + 1'b1));
            out_next.print_valid  = pvalid;
            out_next.print_value  = IMM_W'(pval);
            out_next.status       = status;
            out_next.halted_flag  = halted_next;
        end

        if (cfg_we)
        begin
            pc_next = PC_W'(cfg_wdata);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= S_IDLE;
            pc_reg        <= '0;
            cnt_reg       <= '0;
            depth_reg     <= '0;
            halted_reg    <= 1'b0;
            dcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < CALL_DEPTH; i++)
            begin
                fvalid_reg[i] <= '0;
            end
        end
        else
        begin
            st_reg        <= st_next;
            pc_reg        <= pc_next;
            cnt_reg       <= cnt_next;
            depth_reg     <= depth_next;
            halted_reg    <= halted_next;
            dcnt_reg      <= dcnt_next;
            out_valid_reg <= out_valid_next;
            fvalid_reg    <= fvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        tos_reg  <= tos_next;
        ret_reg  <= ret_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dmb_reg  <= dmb_next;
        dneg_reg <= dneg_next;
        out_reg  <= out_next;
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(STACK_DEPTH))
        else $error("operand stack count beyond depth");

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        {{(32 - CD_W){1'b0}}, depth_reg} < CALL_DEPTH)
        else $error("call depth beyond frame count");

    a_halt_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("halted flag cleared without reset");

    a_start_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == S_EXEC) |-> !out_valid_reg)
        else $error("execution began while a result was still held");

endmodule

`default_nettype wire
